/* rtl/qye_pkg.sv */
package qye_pkg;

    localparam int QUAT_W         = 16;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int CORDIC_STAGES  = 16;
    localparam int ATAN_LEN       = 24;
    localparam int NUM_STAGES     = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

    localparam int TOL_W          = 8;
    localparam logic [TOL_W-1:0] TOL_RESET = 8'd1;

    localparam int DIFF_W = ((QUAT_FRAC_BITS + 1 > QUAT_W) ? QUAT_FRAC_BITS + 1 : QUAT_W) + 2;

    // vector is (w,z) * 2^14, gain of the rotator and a pi pre-turn need headroom
    localparam int VEC_SHIFT  = 14;
    localparam int VEC_W      = QUAT_W + VEC_SHIFT + 3;

    // angle accumulator, 2^31 per pi
    localparam int ACC_W      = 34;
    localparam int ROUND_SHIFT = 17;
    localparam int Q_W        = ACC_W - ROUND_SHIFT;
    localparam int ANGLE_W    = 16;

    localparam logic signed [ACC_W-1:0] ANGLE_PI   = 34'sd2147483648;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 34'sd65536;
    localparam logic signed [Q_W-1:0]   ANGLE_MAX  = 17'sd16384;
    localparam logic signed [Q_W-1:0]   ANGLE_MIN  = -17'sd16384;

    localparam logic signed [ACC_W-1:0] ATAN_TAB [ATAN_LEN] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
        34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
        34'sd652,       34'sd326,       34'sd163,       34'sd81
    };

    typedef struct packed {
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic signed [ACC_W-1:0] acc;
        logic                    zero_out;
        logic                    degen;
    } t_cordic_word;

endpackage

/* rtl/qye_quat_if.sv */
interface qye_quat_if
    import qye_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

/* rtl/qye_yaw_if.sv */
interface qye_yaw_if
    import qye_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic                      degenerate;

    modport source (output valid, yaw_angle, degenerate, input ready);
    modport sink   (input valid, yaw_angle, degenerate, output ready);
endinterface

/* rtl/qye_cordic.sv */
module qye_cordic
    import qye_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  t_cordic_word i_word,
    output logic         o_valid,
    input  logic         i_ready,
    output t_cordic_word o_word
);

    logic         r_vld  [NUM_STAGES];
    t_cordic_word r_word [NUM_STAGES];
    logic         stage_rdy [NUM_STAGES];

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        t_cordic_word            src;
        logic                    src_vld;
        logic                    next_rdy;
        t_cordic_word            n_word;
        logic signed [VEC_W-1:0] dx;
        logic signed [VEC_W-1:0] dy;

        if (k == 0) begin : g_first
            assign src     = i_word;
            assign src_vld = i_valid;
        end else begin : g_mid
            assign src     = r_word[k-1];
            assign src_vld = r_vld[k-1];
        end

        if (k == NUM_STAGES - 1) begin : g_last
            assign next_rdy = i_ready;
        end else begin : g_next
            assign next_rdy = stage_rdy[k+1];
        end

        assign stage_rdy[k] = !r_vld[k] || next_rdy;

        // one micro-rotation, direction from sign of vy
        always_comb begin
            dx     = src.vy >>> k;
            dy     = src.vx >>> k;
            n_word = src;
            if (src.vy > 0) begin
                n_word.vx  = src.vx + dx;
                n_word.vy  = src.vy - dy;
                n_word.acc = src.acc + ATAN_TAB[k];
            end else begin
                n_word.vx  = src.vx - dx;
                n_word.vy  = src.vy + dy;
                n_word.acc = src.acc - ATAN_TAB[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (stage_rdy[k]) begin
                r_vld[k] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (stage_rdy[k] && src_vld) begin
                r_word[k] <= n_word;
            end
        end
    end

    assign o_ready = stage_rdy[0];
    assign o_valid = r_vld[NUM_STAGES-1];
    assign o_word  = r_word[NUM_STAGES-1];

endmodule

/* rtl/quaternion_yaw_extract.sv */
// Twist angle of a quaternion about the z axis, 2*atan2(z,w) in binary angle units with
// 8192 per pi, clamped to -16384..16384; x and y are ignored. A w within the identity
// tolerance of 1.0 gives angle 0, and w = z = 0 gives angle 0 with degenerate set. The
// block takes one word per cycle when the output is not stalled. Each accepted word passes
// through a register for range reduction, the 16-stage vectoring CORDIC, and a register
// for rounding and clamping. Every stage holds its word under back-pressure, so stalls
// lose nothing and bubbles are squeezed out.
module quaternion_yaw_extract
    import qye_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tol_we,
    input  logic [TOL_W-1:0] i_tol_data,
    qye_quat_if.sink         i_quat,
    qye_yaw_if.source        o_yaw
);

    localparam logic signed [DIFF_W-1:0] ONE_Q = DIFF_W'(1) <<< QUAT_FRAC_BITS;

    logic [TOL_W-1:0] r_tol;

    logic                     r_prep_vld;
    t_cordic_word             r_prep;
    t_cordic_word             n_prep;
    logic                     prep_rdy;

    logic signed [QUAT_W-1:0] w;
    logic signed [QUAT_W-1:0] z;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] abs_diff;
    logic                     near_one;
    logic                     w_z_zero;
    logic signed [VEC_W-1:0]  w_scaled;
    logic signed [VEC_W-1:0]  z_scaled;

    logic                     cor_vld;
    logic                     cor_rdy;
    t_cordic_word             cor_word;

    logic                     r_out_vld;
    logic signed [ANGLE_W-1:0] r_yaw;
    logic                     r_degen;
    logic signed [ANGLE_W-1:0] n_yaw;
    logic                     out_rdy;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [Q_W-1:0]    q;
    logic signed [Q_W-1:0]    q_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_tol_we) begin
            r_tol <= i_tol_data;
        end
    end

    // range reduction and special cases
    assign w = i_quat.quat_w;
    assign z = i_quat.quat_z;

    always_comb begin
        diff     = DIFF_W'(w) - ONE_Q;
        abs_diff = (diff < 0) ? -diff : diff;
        near_one = $unsigned(abs_diff) <= DIFF_W'(r_tol);
        w_z_zero = (w == '0) && (z == '0);
        w_scaled = VEC_W'(w) <<< VEC_SHIFT;
        z_scaled = VEC_W'(z) <<< VEC_SHIFT;

        n_prep.zero_out = near_one || w_z_zero;
        n_prep.degen    = !near_one && w_z_zero;
        if (w < 0) begin
            n_prep.vx  = -w_scaled;
            n_prep.vy  = -z_scaled;
            n_prep.acc = (z >= 0) ? ANGLE_PI : -ANGLE_PI;
        end else begin
            n_prep.vx  = w_scaled;
            n_prep.vy  = z_scaled;
            n_prep.acc = '0;
        end
    end

    assign prep_rdy     = !r_prep_vld || cor_rdy;
    assign i_quat.ready = prep_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_vld <= 1'b0;
        end else if (prep_rdy) begin
            r_prep_vld <= i_quat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (prep_rdy && i_quat.valid) begin
            r_prep <= n_prep;
        end
    end

    qye_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_prep_vld),
        .o_ready (cor_rdy),
        .i_word  (r_prep),
        .o_valid (cor_vld),
        .i_ready (out_rdy),
        .o_word  (cor_word)
    );

    // round half up, clamp, apply forced zero
    always_comb begin
        rnd = cor_word.acc + ROUND_HALF;
        q   = $signed(rnd[ACC_W-1:ROUND_SHIFT]);
        if (q > ANGLE_MAX) begin
            q_clamp = ANGLE_MAX;
        end else if (q < ANGLE_MIN) begin
            q_clamp = ANGLE_MIN;
        end else begin
            q_clamp = q;
        end
        n_yaw = cor_word.zero_out ? '0 : ANGLE_W'(q_clamp);
    end

    assign out_rdy = !r_out_vld || o_yaw.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_rdy) begin
            r_out_vld <= cor_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && cor_vld) begin
            r_yaw   <= n_yaw;
            r_degen <= cor_word.degen;
        end
    end

    assign o_yaw.valid      = r_out_vld;
    assign o_yaw.yaw_angle  = r_yaw;
    assign o_yaw.degenerate = r_degen;

endmodule
